// ----- hdl/aes_block_cipher_top_macros.svh -----
// Assertion macros for the AES block cipher files, used by the AES controller.
`ifndef AES_BLOCK_CIPHER_TOP_MACROS_SVH
`define AES_BLOCK_CIPHER_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hdl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES package
// Types, constants and byte-level functions shared by the cipher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package aes_pkg;

  // Round key store: one 128-bit row per round key, fully decoded index.
  localparam int RK_ROWS = 16;

  // Register indexes.
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_KLEN = 3'd4;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXPAND, ST_LOAD, ST_ROUND, ST_DONE
  } aes_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;      // load input block with first key addition
    logic       round;     // perform one round
    logic       last;      // round is the final one (no mix)
    logic       exp_init;  // start key expansion
    logic       exp_step;  // produce one schedule word
    logic [3:0] rnd;       // round key index in use
  } aes_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic exp_done;
  } aes_stat_t;

  typedef logic [7:0] byte_t;

  function automatic byte_t sbox(input byte_t a);
    byte_t t [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic byte_t sbox_inv(input byte_t a);
    byte_t t [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Forward column mix on one 32-bit column, row 0 in the top byte.
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    byte_t a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // Inverse mix: a premultiply by {05,00,04,00} then the forward mix.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    byte_t a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

endpackage

// ----- hdl/aes_ctrl.sv -----
// ----------------------------------------------------------------------------
// AES controller
// Sequences key expansion and the rounds of one block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aes_block_cipher_top_macros.svh"
module aes_ctrl import aes_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       in_op,
  input  logic       keys_ok,
  input  logic [1:0] klen,
  input  aes_stat_t  stat,
  input  logic       out_ready,
  output logic       in_ready,
  output logic       out_valid,
  output logic       keys_set,
  output aes_cmd_t   cmd
);

  aes_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       op_r, op_nxt;
  logic [3:0] nr;

  assign nr = (klen == 2'd0) ? 4'd10 : (klen == 2'd1) ? 4'd12 : 4'd14;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      op_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
    end
  end

  // Next state and commands; cnt holds the number of the round in progress.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    keys_set  = 1'b0;
    cmd.rnd   = (op_r == OP_DEC) ? nr - cnt_r : cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // The first key of the offered block is fetched while it transfers.
        cmd.rnd  = (in_op == OP_DEC) ? nr : 4'd0;
        if (in_fire) begin
          op_nxt  = in_op;
          cnt_nxt = '0;
          if (keys_ok) begin
            state_nxt = ST_LOAD;
          end else begin
            cmd.exp_init = 1'b1;
            state_nxt    = ST_EXPAND;
          end
        end
      end
      ST_EXPAND: begin
        cmd.exp_step = 1'b1;
        if (stat.exp_done) begin
          keys_set  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = 4'd1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.last  = (cnt_r == nr);
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == nr) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `AES_ASSERT_NXT(a_load_then_round, clk, rst_n, state_r == ST_LOAD, state_r == ST_ROUND,
    "load not followed by a round")
  `AES_ASSERT_IMP(a_cnt_bound, clk, rst_n, state_r == ST_ROUND, cnt_r <= nr && cnt_r != 4'd0,
    "round count out of range")
  `AES_ASSERT_NXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid,
    "result dropped before transfer")

endmodule

// ----- hdl/aes_dp.sv -----
// ----------------------------------------------------------------------------
// AES datapath
// Key schedule unit, round key store and one shared round unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes_dp import aes_pkg::*; (
  input  logic          clk,
  input  aes_cmd_t      cmd,
  input  logic          op,
  input  logic [1:0]    klen,
  input  logic [255:0]  key,
  input  logic [127:0]  blk_in,
  output aes_stat_t     stat,
  output logic [127:0]  blk_out
);

  logic [127:0] rk_mem [RK_ROWS];
  logic [127:0] rk_q;

  // Key expansion: a sliding window of the last eight words.
  logic [31:0] win_r [8];
  logic [31:0] win_nxt [8];
  logic [5:0]  wi_r;
  logic [2:0]  ph_r;     // i mod nk
  logic [7:0]  rc_r;
  logic [5:0]  total, wi_nxt;
  logic [2:0]  nkm1, ph_nxt;
  logic [7:0]  rc_nxt;
  logic [31:0] t, wnew;
  logic        wr_en;
  logic [31:0] wr_data;

  assign nkm1  = (klen == 2'd0) ? 3'd3 : (klen == 2'd1) ? 3'd5 : 3'd7;
  assign total = (klen == 2'd0) ? 6'd44 : (klen == 2'd1) ? 6'd52 : 6'd60;

  // Word i = word i-nk xor transform of word i-1; window slot 0 is newest.
  always_comb begin
    t = win_r[0];
    if (ph_r == 3'd0) t = sbox_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rc_r, 24'h0};
    else if (nkm1 == 3'd7 && ph_r == 3'd4) t = sbox_word(win_r[0]);
    wnew = win_r[nkm1] ^ t;
  end

  always_comb begin
    for (int k = 0; k < 8; k++) win_nxt[k] = win_r[k];
    wi_nxt  = wi_r;
    ph_nxt  = ph_r;
    rc_nxt  = rc_r;
    wr_en   = 1'b0;
    wr_data = wnew;
    if (cmd.exp_init) begin
      // Key words in reverse order so that word nk-1 sits in slot 0.
      for (int k = 0; k < 8; k++)
        win_nxt[k] = key[32*k +: 32];
      if (klen == 2'd0) for (int k = 0; k < 4; k++) win_nxt[k] = key[128 + 32*k +: 32];
      if (klen == 2'd1) for (int k = 0; k < 6; k++) win_nxt[k] = key[64 + 32*k +: 32];
      wi_nxt = '0;
      ph_nxt = '0;
      rc_nxt = 8'h01;
    end else if (cmd.exp_step && wi_r != total) begin
      wr_en = 1'b1;
      wi_nxt = wi_r + 6'd1;
      if (wi_r <= {3'd0, nkm1}) begin
        // Copy the key words themselves first.
        wr_data = win_r[nkm1 - wi_r[2:0]];
      end else begin
        for (int k = 7; k > 0; k--) win_nxt[k] = win_r[k-1];
        win_nxt[0] = wnew;
        ph_nxt = (ph_r == nkm1) ? 3'd0 : ph_r + 3'd1;
        if (ph_r == 3'd0) rc_nxt = xtime(rc_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) win_r[k] <= win_nxt[k];
    wi_r <= wi_nxt;
    ph_r <= ph_nxt;
    rc_r <= rc_nxt;
  end

  // The copy phase ends with the phase counter at zero for the first derived word.
  assign stat.exp_done = cmd.exp_step && (wi_r == total);

  // Round key store: one row per round key, each schedule word written to its
  // lane of the row, word 0 in the top lane. The top row is never written.
  logic [3:0] rnd_fetch;
  assign rnd_fetch = (op == OP_DEC) ? cmd.rnd - 4'd1 : cmd.rnd + 4'd1;

  always_ff @(posedge clk) begin
    if (wr_en) rk_mem[wi_r[5:2]][{~wi_r[1:0], 5'b00000} +: 32] <= wr_data;
  end

  // Registered read of the key needed in the next cycle.
  logic [3:0] rnd_pre;
  always_comb begin
    rnd_pre = cmd.rnd;
    if (cmd.load || cmd.round) rnd_pre = rnd_fetch;
  end

  always_ff @(posedge clk) begin
    rk_q <= rk_mem[rnd_pre];
  end

  // Round unit.
  logic [127:0] st_r, st_nxt, sr, sb;
  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (op == OP_ENC)
          sr[127 - 8*(4*c + r) -: 8] = st_r[127 - 8*(4*((c + r) % 4) + r) -: 8];
        else
          sr[127 - 8*(4*((c + r) % 4) + r) -: 8] = st_r[127 - 8*(4*c + r) -: 8];
      end
    for (int i = 0; i < 16; i++)
      sb[8*i +: 8] = (op == OP_ENC) ? sbox(sr[8*i +: 8]) : sbox_inv(sr[8*i +: 8]);
    st_nxt = st_r;
    if (cmd.load) st_nxt = blk_in ^ rk_q;
    else if (cmd.round) begin
      if (op == OP_ENC) begin
        for (int c = 0; c < 4; c++)
          st_nxt[127 - 32*c -: 32] = (cmd.last ? sb[127 - 32*c -: 32]
                                     : mix_col(sb[127 - 32*c -: 32])) ^ rk_q[127 - 32*c -: 32];
      end else begin
        for (int c = 0; c < 4; c++)
          st_nxt[127 - 32*c -: 32] = cmd.last ? sb[127 - 32*c -: 32] ^ rk_q[127 - 32*c -: 32]
                                     : inv_mix_col(sb[127 - 32*c -: 32] ^ rk_q[127 - 32*c -: 32]);
      end
    end
  end

  always_ff @(posedge clk) st_r <= st_nxt;

  assign blk_out = st_r;

endmodule

// ----- hdl/aes_block_cipher_top.sv -----
// ----------------------------------------------------------------------------
// AES block cipher top level
// ECB encryption and decryption of 128-bit blocks with 128/192/256-bit keys.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in      | input     | in_valid/in_ready  | operation, block_high, block_low
//  out     | output    | out_valid/out_ready| result_high, result_low
//  cfg     | input     | APB psel/penable   | key parts, key length
//
// A load state and then Nr rounds, one a cycle on the single shared round unit,
// lead to the done state, where the result is offered until out_ready takes it;
// the controller then returns to idle before it accepts the next block.
// The first block after reset or after a write to a key or key length register first
// expands the key, writing one schedule word a cycle into the key store.
// Reset is synchronous and active low. A result held by out_ready stalls input.
`timescale 1ns / 1ps
module aes_block_cipher_top import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] key_r [4];
  logic [1:0]  klen_r, klen_eff;
  logic        keys_ok_r, keys_set, cfg_wr;
  logic [127:0] blk_in_r, blk_out;
  logic        op_r, in_fire;
  aes_cmd_t    cmd;
  aes_stat_t   stat;
  logic [2:0]  reg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign reg_idx  = paddr[5:3];
  assign klen_eff = (klen_r == 2'd3) ? 2'd2 : klen_r;
  assign in_fire  = in_valid && in_ready;

  // Register file and the key-valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) key_r[k] <= '0;
      klen_r    <= '0;
      keys_ok_r <= 1'b0;
    end else begin
      if (keys_set) keys_ok_r <= 1'b1;
      if (cfg_wr && paddr[2:0] == 3'd0) begin
        unique case (reg_idx)
          REG_KEY0: begin key_r[0] <= pwdata; keys_ok_r <= 1'b0; end
          REG_KEY1: begin key_r[1] <= pwdata; keys_ok_r <= 1'b0; end
          REG_KEY2: begin key_r[2] <= pwdata; keys_ok_r <= 1'b0; end
          REG_KEY3: begin key_r[3] <= pwdata; keys_ok_r <= 1'b0; end
          REG_KLEN: begin klen_r <= pwdata[1:0]; keys_ok_r <= 1'b0; end
          default: ;
        endcase
      end
    end
  end

  // Read-back.
  always_comb begin
    unique case (reg_idx)
      REG_KEY0: prdata = key_r[0];
      REG_KEY1: prdata = key_r[1];
      REG_KEY2: prdata = key_r[2];
      REG_KEY3: prdata = key_r[3];
      REG_KLEN: prdata = {62'd0, klen_r};
      default:  prdata = '0;
    endcase
  end

  // Input capture register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      blk_in_r <= {in_block_high, in_block_low};
      op_r     <= in_operation;
    end
  end

  aes_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(in_operation),
    .keys_ok(keys_ok_r), .klen(klen_eff), .stat(stat), .out_ready(out_ready),
    .in_ready(in_ready), .out_valid(out_valid), .keys_set(keys_set), .cmd(cmd)
  );

  aes_dp u_dp (
    .clk(clk), .cmd(cmd), .op(op_r), .klen(klen_eff),
    .key({key_r[0], key_r[1], key_r[2], key_r[3]}), .blk_in(blk_in_r),
    .stat(stat), .blk_out(blk_out)
  );

  assign out_result_high = blk_out[127:64];
  assign out_result_low  = blk_out[63:0];

endmodule
